FILE: rtl/gbpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2) Boolean polynomial engine - shared definitions
// Command codes, sequencer states and the default variable count.
// ----------------------------------------------------------------------------
package gbpe_pkg;

	localparam int NUM_VARS_DEF = 8;

	// Codes above CMD_REPORT behave as a report.
	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_MULT   = 3'd2,
		CMD_SUBST  = 3'd3,
		CMD_EVAL   = 3'd4,
		CMD_REPORT = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_REWR,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/gf2_boolean_polynomial_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2) Boolean polynomial engine
// Holds one polynomial in algebraic normal form, one presence bit per
// monomial mask, and applies one command per input transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries cmd, mono and values. Output
//   channel out_valid/out_ready carries eval_bit, degree and used_vars, one
//   result per command, taken after the command has been applied.
//   The block handles one command at a time; in_ready is high only when idle.
//   Every command ends with a scan of all 2^NUM_VARS terms, one term per
//   cycle through the term memory read port.
//   Multiply and substitute first sweep all terms into a scratch memory
//   (one read-modify-write per cycle with a one-entry bypass), then the scan
//   copies scratch back.
//   After reset a clearing pass zeroes both memories; in_ready stays low
//   meanwhile.
//   The result sits in an output register. While the receiver stalls, the
//   finished result holds; a following command may already be accepted and
//   worked on, and it waits for the output register before it completes.
// ----------------------------------------------------------------------------
module gf2_boolean_polynomial_engine
	import gbpe_pkg::*;
#(
	parameter int NUM_VARS = NUM_VARS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [7:0]        mono,
	input  logic [7:0]        values,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              eval_bit,
	output logic signed [4:0] degree,
	output logic [7:0]        used_vars
);

	localparam int IDX_W      = NUM_VARS;
	localparam int TERM_COUNT = 1 << NUM_VARS;
	localparam int DEG_W      = $clog2(NUM_VARS + 1);

	state_t state_q, state_d;

	// command registers
	logic [2:0]       cmd_q;
	logic [IDX_W-1:0] mono_q;
	logic [IDX_W-1:0] vals_q;

	// sequencer
	logic [IDX_W:0]   cnt_q;
	logic [IDX_W-1:0] t;
	logic             issue;
	logic             phase_done;
	logic             accept;
	logic             out_load;

	// memories
	logic             pres_mem [TERM_COUNT];
	logic             scr_mem  [TERM_COUNT];
	logic             pres_we;
	logic             scr_we;
	logic [IDX_W-1:0] scr_raddr;
	logic [IDX_W-1:0] scr_waddr;
	logic             scr_wdata;

	// stage 1
	logic             vld_s1;
	logic [IDX_W-1:0] t_s1;
	logic [IDX_W-1:0] d_s1;
	logic             ok_s1;
	logic             pres_rd_s1;
	logic             scr_rd_s1;
	logic             byp_s1;
	logic             byp_dat_s1;

	// rewrite mapping of the issued term
	logic [IDX_W-1:0] dest;
	logic             dest_ok;
	logic [IDX_W-1:0] sub_y;
	logic             scr_val;
	logic             nw;

	// command decode
	logic is_copy;
	logic is_clear;
	logic is_toggle;
	logic is_eval;
	logic is_write;

	// scan datapath
	logic             v;
	logic [DEG_W-1:0] wt;
	logic             force_zero;
	logic             clr_scr;

	// accumulators and output register
	logic             any_q;
	logic [DEG_W-1:0] deg_acc_q;
	logic [IDX_W-1:0] used_acc_q;
	logic             par_q;
	logic             out_valid_q;
	logic             eval_q;
	logic [4:0]       degree_q;
	logic [7:0]       used_q;

	logic [IDX_W+7:0] mono_pad;
	logic [IDX_W+7:0] vals_pad;
	logic [IDX_W+7:0] used_pad;
	logic [DEG_W+4:0] deg_pad;

	assign mono_pad = {{IDX_W{1'b0}}, mono};
	assign vals_pad = {{IDX_W{1'b0}}, values};
	assign used_pad = {8'd0, used_acc_q};
	assign deg_pad  = {5'd0, deg_acc_q};

	assign t      = cnt_q[IDX_W-1:0];
	assign accept = in_valid && in_ready;

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (phase_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_MULT || cmd == CMD_SUBST) state_d = ST_REWR;
					else state_d = ST_SCAN;
				end
			end
			ST_REWR: begin
				if (phase_done) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (phase_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		issue      = 1'b0;
		phase_done = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_INIT, ST_REWR, ST_SCAN: begin
				issue      = !cnt_q[IDX_W];
				phase_done = cnt_q[IDX_W] && !vld_s1;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (accept || phase_done) cnt_q <= '0;
			else if (issue) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			mono_q <= mono_pad[IDX_W-1:0];
			vals_q <= vals_pad[IDX_W-1:0];
		end
	end

	// ---------------- command decode ----------------
	always_comb begin
		is_copy   = 1'b0;
		is_clear  = 1'b0;
		is_toggle = 1'b0;
		is_eval   = 1'b0;
		is_write  = 1'b1;
		case (cmd_q) inside
			CMD_MULT, CMD_SUBST: is_copy = 1'b1;
			CMD_CLEAR:           is_clear = 1'b1;
			CMD_TOGGLE:          is_toggle = 1'b1;
			CMD_EVAL: begin
				is_eval  = 1'b1;
				is_write = 1'b0;
			end
			default:             is_write = 1'b0;
		endcase
	end

	// ---------------- rewrite mapping ----------------
	assign sub_y = t & mono_q;

	always_comb begin
		if (cmd_q == CMD_MULT) begin
			dest    = t | mono_q;
			dest_ok = 1'b1;
		end else begin
			dest    = t & ~mono_q;
			dest_ok = ((vals_q & sub_y) == sub_y);
		end
	end

	// the previous cycle's write is invisible to this cycle's read: bypass it
	assign scr_val = byp_s1 ? byp_dat_s1 : scr_rd_s1;
	assign nw      = scr_val ^ (pres_rd_s1 & ok_s1);

	always_ff @(posedge clk) begin
		t_s1       <= t;
		d_s1       <= dest;
		ok_s1      <= dest_ok;
		byp_dat_s1 <= nw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
		end else begin
			byp_s1 <= (state_q == ST_REWR) && vld_s1 && (d_s1 == dest);
		end
	end

	// ---------------- scan datapath ----------------
	assign force_zero = (state_q == ST_INIT) || is_clear;
	assign clr_scr    = (state_q == ST_INIT) || is_copy;

	always_comb begin
		if (force_zero) v = 1'b0;
		else if (is_copy) v = scr_rd_s1;
		else v = pres_rd_s1 ^ (is_toggle && (t_s1 == mono_q));
	end

	always_comb begin
		wt = '0;
		for (int i = 0; i < IDX_W; i++) begin
			wt = wt + DEG_W'(t_s1[i]);
		end
	end

	// ---------------- memories ----------------
	assign pres_we   = vld_s1 && (state_q == ST_INIT ||
		(state_q == ST_SCAN && is_write));
	assign scr_raddr = (state_q == ST_REWR) ? dest : t;
	assign scr_waddr = (state_q == ST_REWR) ? d_s1 : t_s1;
	assign scr_wdata = (state_q == ST_REWR) ? nw : 1'b0;
	assign scr_we    = vld_s1 && ((state_q == ST_REWR) ||
		((state_q == ST_SCAN || state_q == ST_INIT) && clr_scr));

	always_ff @(posedge clk) begin
		if (pres_we) pres_mem[t_s1] <= v;
		pres_rd_s1 <= pres_mem[t];
	end

	always_ff @(posedge clk) begin
		if (scr_we) scr_mem[scr_waddr] <= scr_wdata;
		scr_rd_s1 <= scr_mem[scr_raddr];
	end

	// ---------------- accumulators ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q      <= 1'b0;
			deg_acc_q  <= '0;
			used_acc_q <= '0;
			par_q      <= 1'b0;
		end else if (accept) begin
			any_q      <= 1'b0;
			deg_acc_q  <= '0;
			used_acc_q <= '0;
			par_q      <= 1'b0;
		end else if (vld_s1 && state_q == ST_SCAN && v) begin
			any_q      <= 1'b1;
			used_acc_q <= used_acc_q | t_s1;
			if (wt > deg_acc_q) deg_acc_q <= wt;
			if (is_eval && ((t_s1 & ~mono_q) == '0)) par_q <= ~par_q;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			eval_q   <= par_q;
			degree_q <= any_q ? deg_pad[4:0] : 5'h1F;
			used_q   <= used_pad[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign eval_bit  = eval_q;
	assign degree    = degree_q;
	assign used_vars = used_q;

endmodule

FILE: rtl/gbpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GF(2) Boolean polynomial engine - port checker
// Watches the top level's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module gbpe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [2:0]        cmd,
	input logic [7:0]        mono,
	input logic [7:0]        values,
	input logic              out_valid,
	input logic              out_ready,
	input logic              eval_bit,
	input logic signed [4:0] degree,
	input logic [7:0]        used_vars
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(eval_bit) &&
		$stable(degree) && $stable(used_vars))
		else $error("stalled result changed");

	// one command at a time: no back-to-back input transfers
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// the zero polynomial uses no variables
	a_zero_unused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (&degree) |-> used_vars == 8'd0)
		else $error("zero polynomial reports used variables");

	// a polynomial that evaluates to one is not zero
	a_eval_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eval_bit |-> !(&degree))
		else $error("nonzero value from zero polynomial");

endmodule

bind gf2_boolean_polynomial_engine gbpe_checker u_gbpe_checker (.*);
